@@ hdl/canrt_pkg.sv @@
// Package for the CAN identifier rate table: sizes, item types, state codes and helpers.
`timescale 1ns / 1ps
`default_nettype none
package canrt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W       = (FILL_W > 6) ? FILL_W : 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_INSERT,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [28:0] frame_id;
      logic [31:0] second_now;
      logic [5:0]  read_index;
   } req_item_type;

   typedef struct packed {
      logic [28:0] id;
      logic [7:0]  avg;
      logic [7:0]  cnt;
      logic [31:0] total;
      logic [31:0] last;
   } entry_type;

   typedef struct packed {
      logic        hit;
      logic        dropped;
      logic        entry_valid;
      logic [5:0]  entry_slot;
      entry_type   entry;
      logic [6:0]  table_fill;
   } rsp_item_type;

   function automatic logic [5:0] slot_low6(input logic [IDX_W-1:0] s);
      logic [31:0] w;
      w = 32'(s);
      return w[5:0];
   endfunction

   function automatic logic [6:0] fill_low7(input logic [FILL_W-1:0] f);
      logic [31:0] w;
      w = 32'(f);
      return w[6:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/canrt_front.sv @@
// Front end: accepts request items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
`default_nettype none
module canrt_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_mode,
   input  wire  [28:0]              req_frame_id,
   input  wire  [31:0]              req_second_now,
   input  wire  [5:0]               req_read_index,
   output logic                     head_valid,
   output canrt_pkg::req_item_type  head_item,
   input  wire                      head_pop
);
   import canrt_pkg::*;

   req_item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   req_item_type            item;
   logic                    push;
   logic                    pop;

   always_comb begin
      item.op         = req_mode ? OP_READ : OP_FRAME;
      item.frame_id   = req_frame_id;
      item.second_now = req_second_now;
      item.read_index = req_read_index;
   end

   assign req_stall  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/canrt_engine.sv @@
// Back end: table memory, sequential identifier scan, entry update and result register.
`timescale 1ns / 1ps
`default_nettype none
module canrt_engine (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           head_valid,
   input  canrt_pkg::req_item_type       head_item,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output canrt_pkg::rsp_item_type       rsp_item,
   output logic [canrt_pkg::FILL_W-1:0]  fill
);
   import canrt_pkg::*;

   entry_type               tbl_mem [TABLE_DEPTH];
   entry_type               rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_data;

   state_type               state_ff, state_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       scan_ff, scan_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_tag_ff;
   req_item_type            cur_ff;
   entry_type               ent_ff;
   logic [IDX_W-1:0]        slot_ff;
   rsp_item_type            rsp_ff, rsp_in;

   logic                    read_in_range;
   logic                    match;
   logic                    scan_last;
   logic                    same_second;
   logic [8:0]              avg_sum;
   entry_type               upd;

   assign read_in_range = CMP_W'(head_item.read_index) < CMP_W'(fill_ff);
   assign match         = rd_valid_ff && (rd_data_ff.id == cur_ff.frame_id);
   assign scan_last     = rd_valid_ff && (FILL_W'(rd_tag_ff) == fill_ff - 1'b1);
   assign same_second   = (ent_ff.last == cur_ff.second_now);
   assign avg_sum       = 9'(ent_ff.avg) + 9'(ent_ff.cnt);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_item.op == OP_READ) begin
                  state_in = read_in_range ? ST_READ : ST_RESP;
               end else begin
                  state_in = (fill_ff == '0) ? ST_INSERT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = ST_UPDATE;
            end else if (scan_last) begin
               state_in = ST_INSERT;
            end
         end
         ST_UPDATE: state_in = ST_RESP;
         ST_INSERT: state_in = ST_RESP;
         ST_READ:   state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_pop    = 1'b0;
      rd_addr     = scan_ff[IDX_W-1:0];
      rd_valid_in = 1'b0;
      scan_in     = scan_ff;
      fill_in     = fill_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = ent_ff;
      rsp_in      = rsp_ff;

      upd.id    = ent_ff.id;
      upd.cnt   = same_second ? ((ent_ff.cnt == 8'hFF) ? ent_ff.cnt : ent_ff.cnt + 8'd1)
                              : 8'd1;
      upd.avg   = same_second ? ent_ff.avg : avg_sum[8:1];
      upd.last  = cur_ff.second_now;
      upd.total = (ent_ff.total == 32'hFFFF_FFFF) ? ent_ff.total : ent_ff.total + 32'd1;

      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            rd_addr = IDX_W'(head_item.read_index);
            if (head_valid) begin
               head_pop = 1'b1;
               rsp_in.hit         = 1'b0;
               rsp_in.dropped     = 1'b0;
               rsp_in.entry_valid = 1'b0;
               rsp_in.entry_slot  = head_item.read_index;
               rsp_in.entry       = '0;
               rsp_in.table_fill  = fill_low7(fill_ff);
            end
         end
         ST_SCAN: begin
            rd_valid_in = (scan_ff < fill_ff);
            if (scan_ff != fill_ff) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            wr_en              = 1'b1;
            wr_addr            = slot_ff;
            wr_data            = upd;
            rsp_in.hit         = 1'b1;
            rsp_in.dropped     = 1'b0;
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_slot  = slot_low6(slot_ff);
            rsp_in.entry       = upd;
            rsp_in.table_fill  = fill_low7(fill_ff);
         end
         ST_INSERT: begin
            rsp_in.hit = 1'b0;
            if (fill_ff < FILL_W'(TABLE_DEPTH)) begin
               wr_en              = 1'b1;
               wr_addr            = fill_ff[IDX_W-1:0];
               wr_data.id         = cur_ff.frame_id;
               wr_data.avg        = 8'd0;
               wr_data.cnt        = 8'd1;
               wr_data.total      = 32'd1;
               wr_data.last       = cur_ff.second_now;
               fill_in            = fill_ff + 1'b1;
               rsp_in.dropped     = 1'b0;
               rsp_in.entry_valid = 1'b1;
               rsp_in.entry_slot  = slot_low6(fill_ff[IDX_W-1:0]);
               rsp_in.entry       = wr_data;
            end else begin
               rsp_in.dropped     = 1'b1;
               rsp_in.entry_valid = 1'b0;
               rsp_in.entry_slot  = '0;
               rsp_in.entry       = '0;
            end
            rsp_in.table_fill = fill_low7(fill_in);
         end
         ST_READ: begin
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry       = rd_data_ff;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_item  = rsp_ff;
   assign fill      = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rd_tag_ff <= rd_addr;
      rsp_ff    <= rsp_in;
      if (head_pop) begin
         cur_ff <= head_item;
      end
      if (state_ff == ST_SCAN && match) begin
         ent_ff  <= rd_data_ff;
         slot_ff <= rd_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
   end

endmodule
`default_nettype wire

@@ hdl/can_id_rate_table.sv @@
// Top level of the CAN identifier rate table.
//
// Keeps up to 64 CAN identifiers with per-identifier frame totals, per-second
// counts and a running average rate, in a one-read, one-write table memory. A frame
// item is looked up by walking the table one entry per clock; a hit then updates its
// entry, a miss appends one, or is dropped when the table is full. A read item
// returns one entry by index, or no valid entry when the index is not below
// table_fill. A two-item input queue keeps taking items while a result waits on the
// output. Table contents are not cleared at reset; only entries below table_fill
// are ever reported.
`timescale 1ns / 1ps
`default_nettype none
module can_id_rate_table (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire          req_mode,
   input  wire  [28:0]  req_frame_id,
   input  wire  [31:0]  req_second_now,
   input  wire  [5:0]   req_read_index,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic         rsp_hit,
   output logic         rsp_dropped,
   output logic         rsp_entry_valid,
   output logic [5:0]   rsp_entry_slot,
   output logic [28:0]  rsp_entry_id,
   output logic [7:0]   rsp_rate_average,
   output logic [7:0]   rsp_count_this_second,
   output logic [31:0]  rsp_total_frames,
   output logic [31:0]  rsp_last_second,
   output logic [6:0]   rsp_table_fill
);
   import canrt_pkg::*;

   logic               head_valid;
   req_item_type       head_item;
   logic               head_pop;
   rsp_item_type       rsp_item;
   logic [FILL_W-1:0]  fill;

   canrt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_frame_id   (req_frame_id),
      .req_second_now (req_second_now),
      .req_read_index (req_read_index),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop)
   );

   canrt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .fill       (fill)
   );

   assign rsp_hit               = rsp_item.hit;
   assign rsp_dropped           = rsp_item.dropped;
   assign rsp_entry_valid       = rsp_item.entry_valid;
   assign rsp_entry_slot        = rsp_item.entry_slot;
   assign rsp_entry_id          = rsp_item.entry.id;
   assign rsp_rate_average      = rsp_item.entry.avg;
   assign rsp_count_this_second = rsp_item.entry.cnt;
   assign rsp_total_frames      = rsp_item.entry.total;
   assign rsp_last_second       = rsp_item.entry.last;
   assign rsp_table_fill        = rsp_item.table_fill;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= FILL_W'(TABLE_DEPTH))
      else $error("table fill above depth");

   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> fill >= $past(fill))
      else $error("table fill decreased");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (fill == FILL_W'(TABLE_DEPTH) && !rsp_hit))
      else $error("item dropped with room in table");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_entry_valid)
      else $error("hit reported without valid entry");

endmodule
`default_nettype wire

@@ verif/can_id_rate_checker.sv @@
// Checker for the CAN identifier rate table: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module can_id_rate_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          req_stall,
   input  wire          req_mode,
   input  wire  [28:0]  req_frame_id,
   input  wire  [31:0]  req_second_now,
   input  wire  [5:0]   req_read_index,
   input  wire          rsp_valid,
   input  wire          rsp_stall,
   input  wire          rsp_hit,
   input  wire          rsp_dropped,
   input  wire          rsp_entry_valid,
   input  wire  [5:0]   rsp_entry_slot,
   input  wire  [28:0]  rsp_entry_id,
   input  wire  [7:0]   rsp_rate_average,
   input  wire  [7:0]   rsp_count_this_second,
   input  wire  [31:0]  rsp_total_frames,
   input  wire  [31:0]  rsp_last_second,
   input  wire  [6:0]   rsp_table_fill,
   output int           fail_count,
   output int           pending
);
   import canrt_pkg::*;

   entry_type    id_table [TABLE_DEPTH];
   int           ids_in_use;
   rsp_item_type expected_results [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Applies one item to the local copy of the table and returns its result.
   function automatic rsp_item_type rate_table_update(input req_item_type rq);
      rsp_item_type r;
      int           slot;
      int           i;
      bit           found;
      r     = '0;
      slot  = 0;
      found = 1'b0;
      if (rq.op == OP_READ) begin
         r.entry_slot = rq.read_index;
         if (int'(rq.read_index) < ids_in_use) begin
            r.entry_valid = 1'b1;
            r.entry       = id_table[rq.read_index];
         end
         r.table_fill = 7'(ids_in_use);
         return r;
      end
      for (i = 0; i < ids_in_use; i++) begin
         if (!found && id_table[i].id == rq.frame_id) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         if (id_table[slot].last == rq.second_now) begin
            if (id_table[slot].cnt != 8'hFF) id_table[slot].cnt++;
         end else begin
            id_table[slot].avg  = 8'((int'(id_table[slot].avg) + int'(id_table[slot].cnt)) / 2);
            id_table[slot].cnt  = 8'd1;
            id_table[slot].last = rq.second_now;
         end
         if (id_table[slot].total != 32'hFFFF_FFFF) id_table[slot].total++;
         r.hit         = 1'b1;
         r.entry_valid = 1'b1;
         r.entry_slot  = 6'(slot);
         r.entry       = id_table[slot];
      end else if (ids_in_use < TABLE_DEPTH) begin
         slot           = ids_in_use;
         id_table[slot] = '{id: rq.frame_id, avg: 8'd0, cnt: 8'd1, total: 32'd1,
                            last: rq.second_now};
         ids_in_use++;
         r.entry_valid = 1'b1;
         r.entry_slot  = 6'(slot);
         r.entry       = id_table[slot];
      end else begin
         r.dropped = 1'b1;
      end
      r.table_fill = 7'(ids_in_use);
      return r;
   endfunction

   always @(posedge clock) begin
      req_item_type rq;
      rsp_item_type want;
      if (reset) begin
         ids_in_use = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result item with none expected", 32'd0, 32'd0);
            end else begin
               want = expected_results.pop_front();
               check_field("hit", 32'(rsp_hit), 32'(want.hit));
               check_field("dropped", 32'(rsp_dropped), 32'(want.dropped));
               check_field("entry_valid", 32'(rsp_entry_valid), 32'(want.entry_valid));
               check_field("entry_slot", 32'(rsp_entry_slot), 32'(want.entry_slot));
               check_field("entry_id", 32'(rsp_entry_id), 32'(want.entry.id));
               check_field("rate_average", 32'(rsp_rate_average), 32'(want.entry.avg));
               check_field("count_this_second", 32'(rsp_count_this_second),
                           32'(want.entry.cnt));
               check_field("total_frames", rsp_total_frames, want.entry.total);
               check_field("last_second", rsp_last_second, want.entry.last);
               check_field("table_fill", 32'(rsp_table_fill), 32'(want.table_fill));
            end
         end
         if (req_valid && !req_stall) begin
            rq.op         = op_type'(req_mode);
            rq.frame_id   = req_frame_id;
            rq.second_now = req_second_now;
            rq.read_index = req_read_index;
            expected_results.push_back(rate_table_update(rq));
         end
      end
      pending <= expected_results.size();
   end

endmodule

@@ verif/tb_can_id_rate_table.sv @@
// Testbench top for the CAN identifier rate table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_can_id_rate_table;
   import canrt_pkg::*;

   logic         clock          = 1'b0;
   logic         reset          = 1'b1;
   logic         req_valid      = 1'b0;
   logic         req_mode       = 1'b0;
   logic [28:0]  req_frame_id   = '0;
   logic [31:0]  req_second_now = '0;
   logic [5:0]   req_read_index = '0;
   logic         rsp_stall      = 1'b0;
   wire          req_stall;
   wire          rsp_valid;
   wire          rsp_hit;
   wire          rsp_dropped;
   wire          rsp_entry_valid;
   wire  [5:0]   rsp_entry_slot;
   wire  [28:0]  rsp_entry_id;
   wire  [7:0]   rsp_rate_average;
   wire  [7:0]   rsp_count_this_second;
   wire  [31:0]  rsp_total_frames;
   wire  [31:0]  rsp_last_second;
   wire  [6:0]   rsp_table_fill;
   int           fail_count;
   int           pending;

   logic [1:0]   idle_mode  = 2'b11;   // bit 0: sender gaps, bit 1: receiver stalls
   int           stall_left = 0;
   logic [31:0]  sec_now;
   logic [28:0]  known_ids [$];

   can_id_rate_table u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_frame_id          (req_frame_id),
      .req_second_now        (req_second_now),
      .req_read_index        (req_read_index),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_dropped           (rsp_dropped),
      .rsp_entry_valid       (rsp_entry_valid),
      .rsp_entry_slot        (rsp_entry_slot),
      .rsp_entry_id          (rsp_entry_id),
      .rsp_rate_average      (rsp_rate_average),
      .rsp_count_this_second (rsp_count_this_second),
      .rsp_total_frames      (rsp_total_frames),
      .rsp_last_second       (rsp_last_second),
      .rsp_table_fill        (rsp_table_fill)
   );

   can_id_rate_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_frame_id          (req_frame_id),
      .req_second_now        (req_second_now),
      .req_read_index        (req_read_index),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_dropped           (rsp_dropped),
      .rsp_entry_valid       (rsp_entry_valid),
      .rsp_entry_slot        (rsp_entry_slot),
      .rsp_entry_id          (rsp_entry_id),
      .rsp_rate_average      (rsp_rate_average),
      .rsp_count_this_second (rsp_count_this_second),
      .rsp_total_frames      (rsp_total_frames),
      .rsp_last_second       (rsp_last_second),
      .rsp_table_fill        (rsp_table_fill),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) idle_mode <= 2'($urandom);
   end

   always @(posedge clock) begin : rsp_side
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = idle_mode[1] ? $urandom_range(0, 4) : 0;
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   // Returns at the edge where the item is taken; valid stays high for a back-to-back item.
   task automatic send_item(input op_type op, input logic [28:0] id,
                            input logic [31:0] sec, input logic [5:0] idx);
      int gap;
      gap = idle_mode[0] ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= op;
      req_frame_id   <= id;
      req_second_now <= sec;
      req_read_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [28:0] fresh_id();
      logic [28:0] id;
      bit          dup;
      do begin
         id  = 29'($urandom);
         dup = 1'b0;
         foreach (known_ids[k]) if (known_ids[k] == id) dup = 1'b1;
      end while (dup);
      return id;
   endfunction

   // New identifiers join the pool while it is below max_ids; on a full table they are dropped.
   task automatic random_item(input int max_ids);
      int          r;
      logic [28:0] id;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) sec_now = sec_now + 1;
      if ($urandom_range(0, 59) == 0) sec_now = $urandom;
      if (r < 15) begin
         send_item(OP_READ, 29'($urandom), $urandom, 6'($urandom));
      end else if (r < 30 && (known_ids.size() < max_ids || known_ids.size() == TABLE_DEPTH)) begin
         id = fresh_id();
         if (known_ids.size() < TABLE_DEPTH) known_ids.push_back(id);
         send_item(OP_FRAME, id, sec_now, 6'($urandom));
      end else begin
         id = known_ids[$urandom_range(0, known_ids.size() - 1)];
         send_item(OP_FRAME, id, sec_now, 6'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table, inserts at field extremes, same and new second, wrap of the second
      send_item(OP_READ, 29'h0, 32'h0, 6'd0);
      send_item(OP_READ, 29'h1FFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      send_item(OP_FRAME, 29'h0, 32'h0, 6'd0);
      send_item(OP_FRAME, 29'h1FFF_FFFF, 32'hFFFF_FFFF, 6'd63);
      send_item(OP_FRAME, 29'h0, 32'h0, 6'd0);
      send_item(OP_FRAME, 29'h0, 32'h0, 6'd0);
      send_item(OP_FRAME, 29'h0, 32'h1, 6'd0);
      send_item(OP_FRAME, 29'h1FFF_FFFF, 32'h0, 6'd0);
      send_item(OP_FRAME, 29'h1555_5555, 32'hAAAA_AAAA, 6'h2A);
      send_item(OP_FRAME, 29'h0AAA_AAAA, 32'h5555_5555, 6'h15);
      send_item(OP_FRAME, 29'h0AAA_AAAA, 32'h5555_5555, 6'h15);
      send_item(OP_FRAME, 29'h1555_5555, 32'hAAAA_AAAB, 6'h2A);
      send_item(OP_READ, 29'h0, 32'h0, 6'd0);
      send_item(OP_READ, 29'h0, 32'h0, 6'd1);
      send_item(OP_READ, 29'h0, 32'h0, 6'd2);
      send_item(OP_READ, 29'h0, 32'h0, 6'd3);
      send_item(OP_READ, 29'h0, 32'h0, 6'd4);
      send_item(OP_READ, 29'h0, 32'h0, 6'd63);
      known_ids = '{29'h0, 29'h1FFF_FFFF, 29'h1555_5555, 29'h0AAA_AAAA};

      sec_now = 32'hFFFF_FFF0;
      repeat (200) random_item(12);

      // drive one identifier past the per-second count limit, then into a new second
      sec_now = sec_now + 1;
      repeat (260) send_item(OP_FRAME, known_ids[0], sec_now, 6'($urandom));
      send_item(OP_FRAME, known_ids[0], sec_now + 1, 6'($urandom));
      send_item(OP_READ, 29'($urandom), $urandom, 6'd0);

      req_valid <= 1'b0;
      wait_drained();

      while (known_ids.size() < TABLE_DEPTH) begin
         if ($urandom_range(0, 4) == 0) begin
            random_item(0);
         end else begin
            known_ids.push_back(fresh_id());
            send_item(OP_FRAME, known_ids[$], sec_now, 6'($urandom));
         end
      end

      repeat (280) random_item(TABLE_DEPTH);

      req_valid <= 1'b0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ can_id_rate_table.f @@
hdl/canrt_pkg.sv
hdl/canrt_front.sv
hdl/canrt_engine.sv
hdl/can_id_rate_table.sv
verif/can_id_rate_checker.sv
verif/tb_can_id_rate_table.sv
